// ===== hdl/ftg_pkg.sv =====
// ----------------------------------------------------------------------------
// ftg_pkg
// Shared widths, constants, register codes, stage payload types and the
// elaboration-time builder for the 2^-u fraction table.
// ----------------------------------------------------------------------------
package ftg_pkg;

  // Field and datapath widths.
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned WEIGHT_W  = 17;
  localparam int unsigned SQ_W      = 62;
  localparam int unsigned EXP_N_W   = 5;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned ENTRY_W   = 33;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLATEAU_HALF_WIDTH = 1'b0,
    CFG_DECAY_RATE         = 1'b1
  } cfg_idx_e;

  // Constants.
  localparam logic [MAG_W-1:0]    MAG_SAT    = 31'h7fff_ffff;
  localparam logic [DIST_W-1:0]   DIST_MIN   = 32'h8000_0000;
  localparam logic [RATE_W-1:0]   RATE_RESET = 32'd65536;
  localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [30:0]         LOG2E_Q30  = 31'd1549082005;
  localparam logic [63:0]         LN2_Q32    = 64'd2977044472;

  // Payload after the squaring stages.
  typedef struct packed {
    logic            plat;
    logic [SQ_W-1:0] sq;
  } sq_t;

  // Payload after the exponent argument stages.
  typedef struct packed {
    logic               plat;
    logic               zero;
    logic [EXP_N_W-1:0] n;
    logic [FRAC_W-1:0]  frac;
  } arg_t;

  // Entry k of the 2^(-k/2^bits) table in Q.32, from a truncated
  // alternating series for exp(-k*ln2/2^bits). Used at elaboration only.
  function automatic logic [ENTRY_W-1:0] exp2_entry(input int k, input int bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = (64'(k) * LN2_Q32) >> bits;
    term = 64'h1_0000_0000;
    sum  = term;
    for (int j = 1; j <= 24; j++) begin
      term = ((term * y) >> 32) / 64'(j);
      if ((j % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[ENTRY_W-1:0];
  endfunction

endpackage

// ===== hdl/ftg_if.sv =====
// ----------------------------------------------------------------------------
// ftg_if
// Valid/ready channels for distance requests and weight results.
// ----------------------------------------------------------------------------
interface ftg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ftg_pkg::DIST_W-1:0]   distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface ftg_out_if;
  logic                                valid;
  logic                                ready;
  logic [ftg_pkg::WEIGHT_W-1:0]        weight;
  logic                                in_plateau;

  modport source (output valid, output weight, output in_plateau, input ready);
  modport sink   (input valid, input weight, input in_plateau, output ready);
endinterface

// ===== hdl/ftg_dist.sv =====
// ----------------------------------------------------------------------------
// ftg_dist
// Stages 1-3: magnitude of the distance, plateau test with offset from the
// half-width, and the exact square of that offset.
// ----------------------------------------------------------------------------
module ftg_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [ftg_pkg::DIST_W-1:0]   distance_i,
  input  logic [ftg_pkg::MAG_W-1:0]    w1_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ftg_pkg::sq_t                 data_o
);

  localparam int unsigned NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  // Each stage loads when it is empty or the stage after it moves.
  always_comb begin
    en[NS] = ready_i;
    for (int k = 0; k < NS; k++) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: magnitude, with the most negative value saturated.
  logic [ftg_pkg::DIST_W-1:0] neg;
  logic [ftg_pkg::MAG_W-1:0]  mag_d, mag_q;

  always_comb begin
    neg = ~distance_i + 32'd1;
    if (distance_i == ftg_pkg::DIST_MIN) begin
      mag_d = ftg_pkg::MAG_SAT;
    end else if (distance_i[ftg_pkg::DIST_W-1]) begin
      mag_d = neg[ftg_pkg::MAG_W-1:0];
    end else begin
      mag_d = distance_i[ftg_pkg::MAG_W-1:0];
    end
  end

  // Stage 2: one subtraction gives both the plateau test and the offset.
  logic [ftg_pkg::MAG_W:0]   diff;
  logic                      plat_d, plat2_q, plat3_q;
  logic [ftg_pkg::MAG_W-1:0] off_d, off_q;

  assign diff   = {1'b0, mag_q} - {1'b0, w1_i};
  assign plat_d = diff[ftg_pkg::MAG_W];
  assign off_d  = diff[ftg_pkg::MAG_W-1:0];

  // Stage 3: exact Q30.32 square.
  logic [ftg_pkg::SQ_W-1:0] sq_d, sq_q;

  assign sq_d = off_q * off_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) mag_q <= mag_d;
    if (en[1]) begin
      plat2_q <= plat_d;
      off_q   <= off_d;
    end
    if (en[2]) begin
      plat3_q <= plat2_q;
      sq_q    <= sq_d;
    end
  end

  assign data_o.plat = plat3_q;
  assign data_o.sq   = sq_q;

endmodule

// ===== hdl/ftg_arg.sv =====
// ----------------------------------------------------------------------------
// ftg_arg
// Stages 4-6: rate times square as two partial products, their exact sum
// with the flush-to-zero test, and scaling by log2(e) into a base-2 exponent.
// ----------------------------------------------------------------------------
module ftg_arg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  ftg_pkg::sq_t                 data_i,
  input  logic [ftg_pkg::RATE_W-1:0]   rate_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ftg_pkg::arg_t                data_o
);

  localparam int unsigned NS     = 3;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned PHI_W  = ftg_pkg::SQ_W;      // 32 x 30 bits
  localparam int unsigned PLO_W  = 64;                 // 32 x 32 bits
  localparam int unsigned ACC_W  = 52;                 // 16.0 in Q46.48 is 2^52
  localparam int unsigned A_LSB  = 24;
  localparam int unsigned A_W    = ACC_W - A_LSB;
  localparam int unsigned PROD_W = A_W + 31;
  localparam int unsigned T_LSB  = 22;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = 0; k < NS; k++) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 4: the two partial products of rate and the 62-bit square.
  logic [PHI_W-1:0] p_hi_d, p_hi_q;
  logic [PLO_W-1:0] p_lo_d, p_lo_q;
  logic             plat4_q;

  assign p_hi_d = rate_i * data_i.sq[ftg_pkg::SQ_W-1:HALF_W];
  assign p_lo_d = rate_i * data_i.sq[HALF_W-1:0];

  // Stage 5: the exact sum; any product at or above 2^52 flushes the weight to zero.
  logic [ACC_W:0]   sum;
  logic             zero_d, zero5_q, zero6_q;
  logic [A_W-1:0]   a24_q;
  logic             plat5_q, plat6_q;

  assign sum    = {1'b0, p_hi_q[ACC_W-HALF_W-1:0], 32'd0} + {1'b0, p_lo_q[ACC_W-1:0]};
  assign zero_d = (|p_hi_q[PHI_W-1:ACC_W-HALF_W]) | (|p_lo_q[PLO_W-1:ACC_W]) | sum[ACC_W];

  // Stage 6: multiply by log2(e) to get integer and fractional exponent.
  logic [PROD_W-1:0] prod;
  logic [ftg_pkg::EXP_N_W+ftg_pkg::FRAC_W-1:0] t_d, t_q;

  assign prod = a24_q * ftg_pkg::LOG2E_Q30;
  assign t_d  = prod[PROD_W-1:T_LSB];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_hi_q  <= p_hi_d;
      p_lo_q  <= p_lo_d;
      plat4_q <= data_i.plat;
    end
    if (en[1]) begin
      a24_q   <= sum[ACC_W-1:A_LSB];
      zero5_q <= zero_d;
      plat5_q <= plat4_q;
    end
    if (en[2]) begin
      t_q     <= t_d;
      zero6_q <= zero5_q;
      plat6_q <= plat5_q;
    end
  end

  assign data_o.plat = plat6_q;
  assign data_o.zero = zero6_q;
  assign data_o.n    = t_q[ftg_pkg::EXP_N_W+ftg_pkg::FRAC_W-1:ftg_pkg::FRAC_W];
  assign data_o.frac = t_q[ftg_pkg::FRAC_W-1:0];

endmodule

// ===== hdl/ftg_exp2.sv =====
// ----------------------------------------------------------------------------
// ftg_exp2
// Stages 7-10: table lookup of 2^-u, linear interpolation, and the integer
// exponent applied as a rounding right shift, with plateau and flush override.
// ----------------------------------------------------------------------------
module ftg_exp2 #(
  parameter int unsigned EXP_TABLE_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ftg_pkg::arg_t                 data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ftg_pkg::WEIGHT_W-1:0]  weight_o,
  output logic                          in_plateau_o
);

  localparam int unsigned NS     = 4;
  localparam int unsigned TAB_N  = (2 ** EXP_TABLE_BITS) + 1;
  localparam int unsigned IDX_W  = EXP_TABLE_BITS + 1;
  localparam int unsigned FB     = ftg_pkg::FRAC_W - EXP_TABLE_BITS;
  localparam int unsigned SLP_W  = 32;
  localparam int unsigned RND_W  = 40;
  localparam int unsigned SH_W   = 6;
  localparam int unsigned E_W    = ftg_pkg::ENTRY_W;

  typedef logic [E_W-1:0] tab_t [TAB_N];

  function automatic tab_t build_tab();
    tab_t tab;
    for (int k = 0; k < TAB_N; k++) begin
      tab[k] = ftg_pkg::exp2_entry(k, EXP_TABLE_BITS);
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = ready_i;
    for (int k = 0; k < NS; k++) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Flags and exponent ride along with the data.
  logic [ftg_pkg::EXP_N_W-1:0] n_7_q, n_8_q, n_9_q;
  logic plat_7_q, plat_8_q, plat_9_q, plat_10_q;
  logic zero_7_q, zero_8_q, zero_9_q;

  // Stage 7: the two neighboring table entries and the slope between them.
  logic [IDX_W-1:0] idx0, idx1;
  logic [E_W-1:0]   e0, e1, ediff;
  logic [E_W-1:0]   e0_7_q, e0_8_q;
  logic [SLP_W-1:0] slope_q;
  logic [FB-1:0]    r_q;

  assign idx0  = {1'b0, data_i.frac[ftg_pkg::FRAC_W-1:FB]};
  assign idx1  = idx0 + IDX_W'(1);
  assign e0    = EXP_TAB[idx0];
  assign e1    = EXP_TAB[idx1];
  assign ediff = e0 - e1;

  // Stage 8: slope times the remainder of the fraction.
  logic [SLP_W+FB-1:0] iprod;
  logic [SLP_W-1:0]    delta_q;

  assign iprod = slope_q * r_q;

  // Stage 9: interpolated mantissa.
  logic [E_W-1:0] m_d, m_q;

  assign m_d = e0_8_q - {1'b0, delta_q};

  // Stage 10: shift by 16+n with round half up, then apply the overrides.
  logic [SH_W-1:0]              shamt;
  logic [RND_W-1:0]             rnd, shifted;
  logic [ftg_pkg::WEIGHT_W-1:0] weight_d, weight_q;

  always_comb begin
    shamt   = SH_W'(n_9_q) + SH_W'(16);
    rnd     = RND_W'(m_q) + (RND_W'(1) << (shamt - SH_W'(1)));
    shifted = rnd >> shamt;
    if (plat_9_q) begin
      weight_d = ftg_pkg::ONE_Q16;
    end else if (zero_9_q) begin
      weight_d = '0;
    end else if (shifted > RND_W'(ftg_pkg::ONE_Q16)) begin
      weight_d = ftg_pkg::ONE_Q16;
    end else begin
      weight_d = shifted[ftg_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e0_7_q   <= e0;
      slope_q  <= ediff[SLP_W-1:0];
      r_q      <= data_i.frac[FB-1:0];
      n_7_q    <= data_i.n;
      plat_7_q <= data_i.plat;
      zero_7_q <= data_i.zero;
    end
    if (en[1]) begin
      delta_q  <= iprod[SLP_W+FB-1:FB];
      e0_8_q   <= e0_7_q;
      n_8_q    <= n_7_q;
      plat_8_q <= plat_7_q;
      zero_8_q <= zero_7_q;
    end
    if (en[2]) begin
      m_q      <= m_d;
      n_9_q    <= n_8_q;
      plat_9_q <= plat_8_q;
      zero_9_q <= zero_8_q;
    end
    if (en[3]) begin
      weight_q  <= weight_d;
      plat_10_q <= plat_9_q;
    end
  end

  assign weight_o     = weight_q;
  assign in_plateau_o = plat_10_q;

endmodule

// ===== hdl/flat_top_gaussian_cutoff_core.sv =====
// ----------------------------------------------------------------------------
// flat_top_gaussian_cutoff_core: flat-top Gaussian weight of a Q16.16 distance.
// An accepted request passes through every registered stage in order to its result.
// Throughput is one request per cycle; stalls hold every stage, bubbles collapse.
// Reset clears all valid bits, sets half-width to 0 and decay rate to 1.0.
// ----------------------------------------------------------------------------
module flat_top_gaussian_cutoff_core #(
  parameter int unsigned EXP_TABLE_BITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ftg_in_if.sink                          req_i,
  ftg_out_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ftg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ftg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Configuration registers.
  logic [ftg_pkg::MAG_W-1:0]  w1_q;
  logic [ftg_pkg::RATE_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q   <= '0;
      rate_q <= ftg_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      case (ftg_pkg::cfg_idx_e'(cfg_idx_i))
        ftg_pkg::CFG_PLATEAU_HALF_WIDTH: w1_q   <= cfg_wdata_i[ftg_pkg::MAG_W-1:0];
        ftg_pkg::CFG_DECAY_RATE:         rate_q <= cfg_wdata_i[ftg_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Distance and square stages.
  logic         sq_valid, sq_ready;
  ftg_pkg::sq_t sq_data;

  ftg_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .ready_o    (req_i.ready),
    .distance_i (req_i.distance),
    .w1_i       (w1_q),
    .valid_o    (sq_valid),
    .ready_i    (sq_ready),
    .data_o     (sq_data)
  );

  // Exponent argument stages.
  logic          arg_valid, arg_ready;
  ftg_pkg::arg_t arg_data;

  ftg_arg u_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .data_i  (sq_data),
    .rate_i  (rate_q),
    .valid_o (arg_valid),
    .ready_i (arg_ready),
    .data_o  (arg_data)
  );

  // Exponential and output stages.
  ftg_exp2 #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp2 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (arg_valid),
    .ready_o      (arg_ready),
    .data_i       (arg_data),
    .valid_o      (rsp_o.valid),
    .ready_i      (rsp_o.ready),
    .weight_o     (rsp_o.weight),
    .in_plateau_o (rsp_o.in_plateau)
  );

endmodule

// ===== hdl/ftg_checker.sv =====
// ----------------------------------------------------------------------------
// ftg_checker
// Port-level checks on the cutoff core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ftg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ftg_pkg::WEIGHT_W-1:0]  out_weight_i,
  input logic                          out_in_plateau_i
);

  // A result never exceeds one.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_weight_i <= ftg_pkg::ONE_Q16)
    else $error("weight above one");

  // A plateau result carries a weight of exactly one.
  a_plateau_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_in_plateau_i) |-> out_weight_i == ftg_pkg::ONE_Q16)
    else $error("plateau result with weight other than one");

  // The pipeline only refuses requests when it is full and the output stalls.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("request refused with room in the pipeline");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_weight_i) && $stable(out_in_plateau_i)))
    else $error("stalled result changed");

endmodule

bind flat_top_gaussian_cutoff_core ftg_checker u_ftg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .out_weight_i     (rsp_o.weight),
  .out_in_plateau_i (rsp_o.in_plateau)
);
